### rtl/ndbd_pkg.sv
`default_nettype none

package ndbd_pkg;

    localparam int unsigned DECIM_DEF           = 9;
    localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned SUM_W    = 36;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned FRAC_W   = 15;
    localparam int unsigned MAG_W    = SUM_W - FRAC_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] q15_t;

    localparam q15_t Q15_MAX = 16'sh7FFF;
    localparam q15_t Q15_MIN = 16'sh8000;

    // sample plus its oscillator values, NCO -> mixer
    typedef struct packed {
        logic restart;
        q15_t sample;
        q15_t cos_v;
        q15_t nsin_v;
    } mix_word_t;

    // finished block sums, accumulator -> scaler
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_i;
        logic signed [SUM_W-1:0] sum_q;
    } blk_sum_t;

    function automatic logic [63:0] taylor_step(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Quarter-wave sine point r in Q15, odd Taylor series to x^13 in Q30.
    // Elaboration-time only.
    function automatic logic [14:0] quarter_sine(int unsigned r, int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        q;
        x    = (HALF_PI_Q30 * 64'(r)) >> (addr_bits - 2);
        term = x;
        acc  = signed'(x);
        term = taylor_step(term, x) / 64'd6;
        acc  = acc - signed'(term);
        term = taylor_step(term, x) / 64'd20;
        acc  = acc + signed'(term);
        term = taylor_step(term, x) / 64'd42;
        acc  = acc - signed'(term);
        term = taylor_step(term, x) / 64'd72;
        acc  = acc + signed'(term);
        term = taylor_step(term, x) / 64'd110;
        acc  = acc - signed'(term);
        term = taylor_step(term, x) / 64'd156;
        acc  = acc + signed'(term);
        if (acc < 0)
        begin
            acc = '0;
        end
        q = (unsigned'(acc) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

endpackage

`default_nettype wire

### rtl/ndbd_in_if.sv
`default_nettype none

interface ndbd_in_if;
    import ndbd_pkg::*;

    logic valid;
    logic ready;
    q15_t sample;
    logic restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

### rtl/ndbd_out_if.sv
`default_nettype none

interface ndbd_out_if;
    import ndbd_pkg::*;

    logic valid;
    logic ready;
    q15_t out_i;
    q15_t out_q;

    modport source (output valid, output out_i, output out_q, input ready);
    modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

`default_nettype wire

### rtl/nco_downmix_boxcar_decimator.sv
`default_nettype none

// Channel   Dir  Payload                    Handshake
// din       in   sample (s16), restart (1)  valid/ready, word taken on valid & ready
// dout      out  out_i (s16), out_q (s16)   valid/ready, word taken on valid & ready
// cfg       in   cfg_wr_data = phase_step   cfg_wr_en, written on the clock edge
//
// Throughput one input word per clock while dout does not stall; one result per
// DECIM input words. Result is registered through the address, table lookup,
// multiply, accumulate, magnitude, reciprocal multiply and round/saturate
// stages after the word that closes its block is taken; the table read and
// the two 16x16 mixes set the per-cycle path.
// Async active-low reset clears phase, block sums, count and all valid bits;
// phase_step resets to 0.
// A stalled dout fills the empty stages first; din.ready drops only once
// every stage between them holds a word.

module nco_downmix_boxcar_decimator #(
    parameter int unsigned DECIM           = ndbd_pkg::DECIM_DEF,
    parameter int unsigned TABLE_ADDR_BITS = ndbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ndbd_pkg::PHASE_W-1:0] cfg_wr_data,
    ndbd_in_if.sink                           din,
    ndbd_out_if.source                        dout
);
    import ndbd_pkg::*;

    logic [PHASE_W-1:0] phase_step_reg;

    mix_word_t mix_word;
    logic      mix_valid;
    logic      mix_ready;
    blk_sum_t  sum_word;
    logic      sum_valid;
    logic      sum_ready;

    // tuning word; the user must write it only while the datapath is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            phase_step_reg <= cfg_wr_data;
        end
    end

    // phase accumulator and quarter-wave sine/cosine lookup
    ndbd_nco #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_nco (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_step (phase_step_reg),
        .din        (din),
        .mix_word   (mix_word),
        .mix_valid  (mix_valid),
        .mix_ready  (mix_ready)
    );

    // I = s*cos, Q = -s*sin, summed over DECIM words
    ndbd_mix_acc #(
        .DECIM (DECIM)
    ) u_mix_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_word  (mix_word),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .sum_word  (sum_word),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready)
    );

    // sum / (DECIM * 2^15), toward zero, clamped to Q15
    ndbd_scale #(
        .DECIM (DECIM)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_word  (sum_word),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .dout      (dout)
    );

endmodule

`default_nettype wire

### rtl/ndbd_nco.sv
`default_nettype none

module ndbd_nco #(
    parameter int unsigned TABLE_ADDR_BITS = ndbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ndbd_pkg::PHASE_W-1:0] phase_step,
    ndbd_in_if.sink                           din,
    output ndbd_pkg::mix_word_t               mix_word,
    output logic                              mix_valid,
    input  wire logic                         mix_ready
);
    import ndbd_pkg::*;

    localparam int unsigned QUARTER = 1 << (TABLE_ADDR_BITS - 2);
    localparam int unsigned IDX_W   = TABLE_ADDR_BITS - 1;

    // quarter-wave table, constant
    logic [14:0] qsin [QUARTER+1];

    for (genvar r = 0; r <= QUARTER; r++)
    begin : g_qsin
        localparam logic [14:0] PT = quarter_sine(r, TABLE_ADDR_BITS);
        assign qsin[r] = PT;
    end

    function automatic q15_t sine_at(logic [TABLE_ADDR_BITS-1:0] a);
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-3:0] rr;
        logic [IDX_W-1:0]           idx;
        q15_t                       v;
        quad = a[TABLE_ADDR_BITS-1 -: 2];
        rr   = a[TABLE_ADDR_BITS-3:0];
        idx  = quad[0] ? (IDX_W'(QUARTER) - {1'b0, rr}) : {1'b0, rr};
        v    = q15_t'({1'b0, qsin[idx]});
        return quad[1] ? -v : v;
    endfunction

    // stage 1: phase -> table address
    logic                       s1_valid_reg;
    logic [TABLE_ADDR_BITS-1:0] s1_addr_reg;
    q15_t                       s1_sample_reg;
    logic                       s1_restart_reg;
    // stage 2: table values
    logic                       s2_valid_reg;
    mix_word_t                  s2_word_reg;

    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] phase_acc_next;
    logic [PHASE_W-1:0] phase_cur;
    logic               s1_ready;
    logic               s2_ready;
    logic               accept;
    logic [TABLE_ADDR_BITS-1:0] cos_addr;

    assign s2_ready  = !s2_valid_reg || mix_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign din.ready = s1_ready;
    assign accept    = din.valid && s1_ready;

    // restart puts this sample at phase zero
    assign phase_cur      = din.restart ? '0 : phase_acc_reg;
    assign phase_acc_next = phase_cur + phase_step;
    assign cos_addr       = s1_addr_reg + TABLE_ADDR_BITS'(QUARTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= din.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg    <= phase_cur[PHASE_W-1 -: TABLE_ADDR_BITS];
            s1_sample_reg  <= din.sample;
            s1_restart_reg <= din.restart;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg.restart <= s1_restart_reg;
            s2_word_reg.sample  <= s1_sample_reg;
            s2_word_reg.cos_v   <= sine_at(cos_addr);
            s2_word_reg.nsin_v  <= -sine_at(s1_addr_reg);
        end
    end

    assign mix_word  = s2_word_reg;
    assign mix_valid = s2_valid_reg;

endmodule

`default_nettype wire

### rtl/ndbd_mix_acc.sv
`default_nettype none

module ndbd_mix_acc #(
    parameter int unsigned DECIM = ndbd_pkg::DECIM_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ndbd_pkg::mix_word_t mix_word,
    input  wire logic                mix_valid,
    output logic                     mix_ready,
    output ndbd_pkg::blk_sum_t       sum_word,
    output logic                     sum_valid,
    input  wire logic                sum_ready
);
    import ndbd_pkg::*;

    // product stage
    logic                      p_valid_reg;
    logic                      p_restart_reg;
    logic signed [PROD_W-1:0]  p_prod_i_reg;
    logic signed [PROD_W-1:0]  p_prod_q_reg;

    // block state
    logic signed [SUM_W-1:0]   sum_i_reg;
    logic signed [SUM_W-1:0]   sum_q_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      sum_valid_reg;
    blk_sum_t                  sum_word_reg;

    logic                      acc_ready;
    logic                      consume;
    logic                      last;
    logic signed [SUM_W-1:0]   base_i;
    logic signed [SUM_W-1:0]   base_q;
    logic signed [SUM_W-1:0]   tot_i;
    logic signed [SUM_W-1:0]   tot_q;
    logic [CNT_W-1:0]          cnt_base;

    assign acc_ready = !sum_valid_reg || sum_ready;
    assign mix_ready = !p_valid_reg || acc_ready;
    assign consume   = p_valid_reg && acc_ready;

    assign base_i   = p_restart_reg ? '0 : sum_i_reg;
    assign base_q   = p_restart_reg ? '0 : sum_q_reg;
    assign cnt_base = p_restart_reg ? '0 : cnt_reg;
    assign tot_i    = base_i + SUM_W'(p_prod_i_reg);
    assign tot_q    = base_q + SUM_W'(p_prod_q_reg);
    assign last     = (cnt_base == CNT_W'(DECIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
            sum_i_reg     <= '0;
            sum_q_reg     <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (mix_ready)
            begin
                p_valid_reg <= mix_valid;
            end
            if (consume)
            begin
                if (last)
                begin
                    sum_i_reg <= '0;
                    sum_q_reg <= '0;
                    cnt_reg   <= '0;
                end
                else
                begin
                    sum_i_reg <= tot_i;
                    sum_q_reg <= tot_q;
                    cnt_reg   <= cnt_base + 1'b1;
                end
            end
            if (acc_ready)
            begin
                sum_valid_reg <= consume && last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_ready && mix_valid)
        begin
            p_restart_reg <= mix_word.restart;
            p_prod_i_reg  <= mix_word.sample * mix_word.cos_v;
            p_prod_q_reg  <= mix_word.sample * mix_word.nsin_v;
        end
        if (consume && last)
        begin
            sum_word_reg.sum_i <= tot_i;
            sum_word_reg.sum_q <= tot_q;
        end
    end

    assign sum_word  = sum_word_reg;
    assign sum_valid = sum_valid_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(DECIM))
        else $error("block count out of range");

    a_block_done: assert property (@(posedge clk) disable iff (!rst_n)
        consume && last |=> sum_valid_reg)
        else $error("completed block did not reach the sum register");

    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        consume && p_restart_reg |=>
            (cnt_reg == CNT_W'(1)) && (sum_i_reg == SUM_W'($past(p_prod_i_reg))))
        else $error("restart did not start a fresh block");

endmodule

`default_nettype wire

### rtl/ndbd_scale.sv
`default_nettype none

module ndbd_scale #(
    parameter int unsigned DECIM = ndbd_pkg::DECIM_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ndbd_pkg::blk_sum_t sum_word,
    input  wire logic               sum_valid,
    output logic                    sum_ready,
    ndbd_out_if.source              dout
);
    import ndbd_pkg::*;

    localparam int unsigned     PW      = 2 * MAG_W;
    // floor(2^MAG_W / DECIM); estimate is low by at most one
    localparam logic [MAG_W-1:0] RECIP   = MAG_W'((1 << MAG_W) / DECIM);
    localparam logic [MAG_W-1:0] DECIM_M = MAG_W'(DECIM);

    // |sum| >> 15 ; trunc(sum / (D*2^15)) = sign * floor(that / D)
    function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] a;
        a = s[SUM_W-1] ? unsigned'(-s) : unsigned'(s);
        return a[SUM_W-1:FRAC_W];
    endfunction

    function automatic logic [MAG_W-1:0] quot_est(logic [MAG_W-1:0] m);
        logic [PW-1:0] p;
        p = PW'(m) * PW'(RECIP);
        return p[PW-1:MAG_W];
    endfunction

    function automatic q15_t finish(logic [MAG_W-1:0] m, logic [MAG_W-1:0] q0, logic neg);
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] q;
        q15_t             res;
        rem = m - MAG_W'(q0 * DECIM_M);
        q   = (rem >= DECIM_M) ? q0 + 1'b1 : q0;
        if (!neg)
        begin
            res = (q > MAG_W'(32767)) ? Q15_MAX : q15_t'(q[15:0]);
        end
        else
        begin
            res = (q > MAG_W'(32768)) ? Q15_MIN : q15_t'(-q[15:0]);
        end
        return res;
    endfunction

    logic             a_valid_reg;
    logic [MAG_W-1:0] a_mag_i_reg;
    logic [MAG_W-1:0] a_mag_q_reg;
    logic             a_neg_i_reg;
    logic             a_neg_q_reg;

    logic             b_valid_reg;
    logic [MAG_W-1:0] b_mag_i_reg;
    logic [MAG_W-1:0] b_mag_q_reg;
    logic [MAG_W-1:0] b_q0_i_reg;
    logic [MAG_W-1:0] b_q0_q_reg;
    logic             b_neg_i_reg;
    logic             b_neg_q_reg;

    logic             c_valid_reg;
    q15_t             c_out_i_reg;
    q15_t             c_out_q_reg;

    logic a_ready;
    logic b_ready;
    logic c_ready;

    assign c_ready   = !c_valid_reg || dout.ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign sum_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= sum_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && sum_valid)
        begin
            a_mag_i_reg <= mag_of(sum_word.sum_i);
            a_mag_q_reg <= mag_of(sum_word.sum_q);
            a_neg_i_reg <= sum_word.sum_i[SUM_W-1];
            a_neg_q_reg <= sum_word.sum_q[SUM_W-1];
        end
        if (b_ready && a_valid_reg)
        begin
            b_mag_i_reg <= a_mag_i_reg;
            b_mag_q_reg <= a_mag_q_reg;
            b_q0_i_reg  <= quot_est(a_mag_i_reg);
            b_q0_q_reg  <= quot_est(a_mag_q_reg);
            b_neg_i_reg <= a_neg_i_reg;
            b_neg_q_reg <= a_neg_q_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_out_i_reg <= finish(b_mag_i_reg, b_q0_i_reg, b_neg_i_reg);
            c_out_q_reg <= finish(b_mag_q_reg, b_q0_q_reg, b_neg_q_reg);
        end
    end

    assign dout.valid = c_valid_reg;
    assign dout.out_i = c_out_i_reg;
    assign dout.out_q = c_out_q_reg;

endmodule

`default_nettype wire

### tb/downmix_average_checker.sv
`default_nettype none

module downmix_average_checker #(
    parameter int unsigned DECIM           = ndbd_pkg::DECIM_DEF,
    parameter int unsigned TABLE_ADDR_BITS = ndbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ndbd_pkg::PHASE_W-1:0] cfg_wr_data,
    ndbd_in_if                                din_mon,
    ndbd_out_if                               dout_mon,
    output int unsigned                       pending,
    output int unsigned                       mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import ndbd_pkg::*;

    localparam int unsigned QUARTER    = 1 << (TABLE_ADDR_BITS - 2);
    localparam int unsigned ADDR_SHIFT = PHASE_W - TABLE_ADDR_BITS;
    localparam longint      DIVISOR    = longint'(DECIM) * 32768;

    typedef struct packed {
        q15_t avg_i;
        q15_t avg_q;
    } iq_avg_t;

    int                 sine_quarter [0:QUARTER];
    logic [PHASE_W-1:0] tuning_word;
    logic [PHASE_W-1:0] nco_phase;
    longint             acc_i;
    longint             acc_q;
    int unsigned        samples_in_block;
    iq_avg_t            expected_averages [$];

    // Q15 quarter-wave point: odd Taylor series to x^13 in unsigned Q30
    function automatic int quarter_point(int unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint unsigned rounded;
        x    = (64'(HALF_PI_Q30) * 64'(r)) / 64'(QUARTER);
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        rounded = (unsigned'(acc) + 64'd16384) >> 15;
        if (rounded > 64'd32767)
        begin
            rounded = 64'd32767;
        end
        return int'(rounded);
    endfunction

    function automatic int sine_lookup(logic [31:0] addr);
        int unsigned a;
        int unsigned quad;
        int unsigned r;
        int          v;
        a    = addr & ((1 << TABLE_ADDR_BITS) - 1);
        quad = a >> (TABLE_ADDR_BITS - 2);
        r    = a & (QUARTER - 1);
        v    = (quad & 1) ? sine_quarter[QUARTER - r] : sine_quarter[r];
        return (quad & 2) ? -v : v;
    endfunction

    // truncating divide, then clamp to Q15
    function automatic q15_t scale_block(longint sum);
        longint v;
        v = sum / DIVISOR;
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    task automatic report_mismatch(string note);
        $display("%0t ns: mismatch: %s", $realtime, note);
        mismatches++;
    endtask

    task automatic clear_block();
        acc_i            = 0;
        acc_q            = 0;
        samples_in_block = 0;
    endtask

    task automatic predict_word(q15_t s, logic restart);
        logic [31:0] addr;
        int          sn;
        int          cs;
        iq_avg_t     avg;
        if (restart)
        begin
            nco_phase = '0;
            clear_block();
        end
        addr = 32'(nco_phase >> ADDR_SHIFT);
        sn   = sine_lookup(addr);
        cs   = sine_lookup(addr + QUARTER);
        acc_i = acc_i + longint'(s) * longint'(cs);
        acc_q = acc_q - longint'(s) * longint'(sn);
        nco_phase = nco_phase + tuning_word;
        samples_in_block++;
        if (samples_in_block >= DECIM)
        begin
            avg.avg_i = scale_block(acc_i);
            avg.avg_q = scale_block(acc_q);
            expected_averages.push_back(avg);
            clear_block();
        end
    endtask

    initial
    begin
        for (int unsigned r = 0; r <= QUARTER; r++)
        begin
            sine_quarter[r] = quarter_point(r);
        end
        mismatches  = 0;
        pending     = 0;
        tuning_word = '0;
        nco_phase   = '0;
        clear_block();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_word = '0;
            nco_phase   = '0;
            clear_block();
            expected_averages.delete();
            pending = 0;
        end
        else
        begin
            if (dout_mon.valid && dout_mon.ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    report_mismatch($sformatf("result I=%0d Q=%0d with nothing expected",
                        dout_mon.out_i, dout_mon.out_q));
                end
                else
                begin
                    iq_avg_t want;
                    want = expected_averages.pop_front();
                    if (dout_mon.out_i !== want.avg_i)
                    begin
                        report_mismatch($sformatf("out_i got %0d, expected %0d",
                            dout_mon.out_i, want.avg_i));
                    end
                    if (dout_mon.out_q !== want.avg_q)
                    begin
                        report_mismatch($sformatf("out_q got %0d, expected %0d",
                            dout_mon.out_q, want.avg_q));
                    end
                end
            end
            if (din_mon.valid && din_mon.ready)
            begin
                predict_word(din_mon.sample, din_mon.restart);
            end
            if (cfg_wr_en)
            begin
                tuning_word = cfg_wr_data;
            end
            pending = expected_averages.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_nco_downmix_boxcar_decimator.sv
`default_nettype none

module tb_nco_downmix_boxcar_decimator;
    timeunit 1ns;
    timeprecision 1ps;

    import ndbd_pkg::*;

    localparam int unsigned DECIM           = DECIM_DEF;
    localparam int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF;
    // PIPE_LAT covers the pipe from closing word to result; pad a little on top
    localparam int unsigned PIPE_LAT        = 7;
    localparam int unsigned SETTLE_CYCLES   = PIPE_LAT + 8;
    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned WORDS_PER_PHASE = 147;
    // limit sits above the slowest legal run (long sender gaps plus long
    // result stalls)
    localparam int unsigned CYCLE_LIMIT     = 600_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [PHASE_W-1:0] cfg_wr_data;
    int unsigned        pending;
    int unsigned        mismatches;
    int unsigned        cycle_count;

    ndbd_in_if  din_ch ();
    ndbd_out_if dout_ch ();

    nco_downmix_boxcar_decimator #(
        .DECIM           (DECIM),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .din         (din_ch),
        .dout        (dout_ch)
    );

    // Predicts the block averages from the words it sees accepted and
    // compares every result word against them.
    downmix_average_checker #(
        .DECIM           (DECIM),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) average_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .din_mon     (din_ch),
        .dout_mon    (dout_ch),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Sender gap: mostly back-to-back, some short holes, a few long ones.
    // In burst mode the sender never idles.
    function automatic int unsigned pick_gap(bit burst);
        int unsigned roll;
        if (burst)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Full-scale values show up often so the extreme averages get hit;
    // the rest is uniform over the whole 16-bit range.
    function automatic q15_t pick_sample();
        logic [31:0] raw;
        int unsigned roll;
        raw  = $urandom;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            return Q15_MAX;
        end
        if (roll == 1)
        begin
            return Q15_MIN;
        end
        return raw[15:0];
    endfunction

    // Present one word at the falling edge, hold it until the rising edge
    // that takes it. valid stays high on exit so back-to-back words see no
    // drop of valid between them.
    task automatic push_word(q15_t s, logic restart);
        @(negedge clk);
        din_ch.valid   <= 1'b1;
        din_ch.sample  <= s;
        din_ch.restart <= restart;
        @(posedge clk);
        while (!din_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            din_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop sending and hold off until every predicted block has come out.
    task automatic drain_results();
        @(negedge clk);
        din_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // A partial block may still sit in the pipe with nothing predicted, so
    // give it the full latency before touching the tuning word.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tuning(logic [PHASE_W-1:0] step);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= step;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: ready high for a random stretch, then a stall that is
    // usually short and now and then long; occasionally a long clean run.
    initial
    begin
        int unsigned hi_len;
        int unsigned lo_len;
        dout_ch.ready = 1'b0;
        forever
        begin
            hi_len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
            lo_len = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
            @(negedge clk);
            dout_ch.ready <= 1'b1;
            repeat (hi_len - 1) @(negedge clk);
            @(negedge clk);
            dout_ch.ready <= 1'b0;
            repeat (lo_len - 1) @(negedge clk);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [PHASE_W-1:0] tuning_plan [NUM_PHASES];
        bit                 burst;

        din_ch.valid   = 1'b0;
        din_ch.sample  = '0;
        din_ch.restart = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        rst_n          = 1'b0;

        // tuning words per random phase: the largest step, one table step per
        // word, half and quarter turn, the smallest nonzero step, random
        tuning_plan[0] = 32'hFFFF_FFFF;
        tuning_plan[1] = 32'h0040_0000;
        tuning_plan[2] = 32'h8000_0000;
        tuning_plan[3] = $urandom;
        tuning_plan[4] = 32'h0000_0001;
        tuning_plan[5] = $urandom;
        tuning_plan[6] = 32'h4000_0000;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, oscillator parked at phase zero (cos full scale,
        // sin zero) so the block sums are easy to reason about.
        write_tuning('0);

        // partial block, then a restart throws it away without a result
        push_word(Q15_MAX, 1'b1);
        push_word(Q15_MIN, 1'b0);
        push_word('0, 1'b0);
        push_word(-16'sd1, 1'b0);
        // restarted full block of most-negative samples: largest magnitude I
        for (int k = 0; k < DECIM; k++)
        begin
            push_word(Q15_MIN, k == 0);
            idle_gap(pick_gap(1'b0));
        end
        // full block of most-positive samples, continuing without restart
        for (int k = 0; k < DECIM; k++)
        begin
            push_word(Q15_MAX, 1'b0);
            idle_gap(pick_gap(1'b0));
        end
        settle();

        // Random part: long well-formed streams, with the odd restart
        // breaking a block in the middle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_tuning(tuning_plan[p]);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (k % 40 == 39)
                begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                // sender backs off mid-stream until the output catches up
                if (p == 3 && k == 70)
                begin
                    drain_results();
                end
                push_word(pick_sample(), $urandom_range(0, 39) == 0);
                idle_gap(pick_gap(burst));
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/ndbd_pkg.sv
rtl/ndbd_in_if.sv
rtl/ndbd_out_if.sv
rtl/ndbd_nco.sv
rtl/ndbd_mix_acc.sv
rtl/ndbd_scale.sv
rtl/nco_downmix_boxcar_decimator.sv
tb/downmix_average_checker.sv
tb/tb_nco_downmix_boxcar_decimator.sv
